// File: src/sesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesc_pkg
// Types, codes and constants shared by the end-stop calibrator and its
// channel interfaces.
// ----------------------------------------------------------------------------
package sesc_pkg;

	// position and derived widths
	localparam int POS_W    = 12;
	localparam int LIM_W    = POS_W + 1;
	localparam int THR_W    = 12;
	localparam int TOL_W    = 12;
	localparam int STILL_W  = 8;
	localparam int POLL_W   = 16;
	localparam int MARGIN_W = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
	localparam logic [STILL_W-1:0] STILL_MAX = {STILL_W{1'b1}};

	// register reset values
	localparam logic [THR_W-1:0]    TRAVEL_RST = 12'd50;
	localparam logic [TOL_W-1:0]    TOL_RST    = 12'd4;
	localparam logic [STILL_W-1:0]  NEEDED_RST = 8'd6;
	localparam logic [POLL_W-1:0]   POLL_RST   = 16'd200;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 11'd0;

	typedef enum logic [1:0] {
		CMD_START_MAX = 2'd0,
		CMD_START_MIN = 2'd1,
		CMD_GOOD      = 2'd2,
		CMD_FAILED    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_MAX_FOUND   = 3'd0,
		ST_DONE        = 3'd1,
		ST_MAX_TIMEOUT = 3'd2,
		ST_MIN_TIMEOUT = 3'd3,
		ST_BAD_ORDER   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRAVEL = 3'd0,
		REG_TOL    = 3'd1,
		REG_NEEDED = 3'd2,
		REG_POLL   = 3'd3,
		REG_MARGIN = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_MAX  = 3'b010,
		PH_MIN  = 3'b100
	} phase_t;

	// absolute difference of two positions
	function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
		input logic [POS_W-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

// File: src/sesc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sesc_if
// Valid/ready channel interfaces for the calibrator: sample requests,
// results and register writes.
// ----------------------------------------------------------------------------
interface sesc_in_if;
	import sesc_pkg::*;
	logic             valid;
	logic             ready;
	cmd_t             cmd;
	logic [POS_W-1:0] position;

	modport source (output valid, output cmd, output position, input ready);
	modport sink   (input valid, input cmd, input position, output ready);
endinterface

interface sesc_out_if;
	import sesc_pkg::*;
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic [POS_W-1:0]        found_step;
	logic [POS_W-1:0]        low_stop;
	logic [POS_W-1:0]        high_stop;
	logic [POS_W-1:0]        mid_step;
	logic [POS_W-1:0]        span_steps;
	logic signed [LIM_W-1:0] limit_halfsteps;

	modport source (output valid, output status, output found_step, output low_stop,
		output high_stop, output mid_step, output span_steps,
		output limit_halfsteps, input ready);
	modport sink   (input valid, input status, input found_step, input low_stop,
		input high_stop, input mid_step, input span_steps,
		input limit_halfsteps, output ready);
endinterface

interface sesc_cfg_if;
	import sesc_pkg::*;
	logic                  valid;
	logic                  ready;
	cfg_reg_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/servo_end_stop_calibrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_end_stop_calibrator_unit
// Two-phase servo end-stop sweep tracker: detects the max and min stops from
// position samples and reports stops, center, span and safe limit.
// ----------------------------------------------------------------------------
// Each request (start or sample) is taken into an input register and handled
// by one pass of compare-and-update logic, once the result register is free or
// draining; that pass writes the phase state and, when a phase ends, the
// result register. The block takes one request per clock; a result sits in
// the output register until taken, and the input side keeps accepting while
// the result side is free or being drained that same cycle.
// Register writes are taken at once (cfg ready is always high) and should
// only be issued while no sweep request is in flight.
module servo_end_stop_calibrator_unit (
	input  logic clk,
	input  logic arst_n,
	sesc_in_if.sink    sample,
	sesc_out_if.source result,
	sesc_cfg_if.sink   cfg
);
	import sesc_pkg::*;

	// configuration registers
	logic [THR_W-1:0]    travel_q;
	logic [TOL_W-1:0]    tol_q;
	logic [STILL_W-1:0]  needed_q;
	logic [POLL_W-1:0]   poll_limit_q;
	logic [MARGIN_W-1:0] margin_q;

	// input stage
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic [POS_W-1:0] pos_s1;

	// phase state
	phase_t             phase_q, phase_d;
	logic               moving_q, moving_d;
	logic [POS_W-1:0]   start_q, start_d;
	logic [POS_W-1:0]   prev_q, prev_d;
	logic [STILL_W-1:0] still_q, still_d;
	logic [POLL_W-1:0]  poll_q, poll_d;
	logic [POS_W-1:0]   max_q, max_d;

	// result register
	logic                    res_valid_q;
	status_t                 status_q, status_d;
	logic [POS_W-1:0]        found_q, found_d;
	logic [POS_W-1:0]        low_q, low_d;
	logic [POS_W-1:0]        high_q, high_d;
	logic [POS_W-1:0]        center_q, center_d;
	logic [POS_W-1:0]        span_q, span_d;
	logic signed [LIM_W-1:0] lim_q, lim_d;

	logic             advance;
	logic             fire_s1;
	logic             emit;
	logic             found;
	logic [POS_W:0]   pair_sum;
	logic [POS_W-1:0] span_w;
	logic [LIM_W:0]   lim_wide;

	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q     <= TRAVEL_RST;
			tol_q        <= TOL_RST;
			needed_q     <= NEEDED_RST;
			poll_limit_q <= POLL_RST;
			margin_q     <= MARGIN_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TRAVEL: travel_q     <= cfg.data[THR_W-1:0];
				REG_TOL:    tol_q        <= cfg.data[TOL_W-1:0];
				REG_NEEDED: needed_q     <= cfg.data[STILL_W-1:0];
				REG_POLL:   poll_limit_q <= cfg.data[POLL_W-1:0];
				REG_MARGIN: margin_q     <= cfg.data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the result register is free or drains
	assign advance      = !res_valid_q || result.ready;
	assign fire_s1      = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			cmd_s1 <= sample.cmd;
			pos_s1 <= sample.position;
		end
	end

	// derived results against the stored max stop
	assign pair_sum = {1'b0, pos_s1} + {1'b0, max_q};
	assign span_w   = max_q - pos_s1;
	assign lim_wide = {2'b00, span_w} - {{(LIM_W - MARGIN_W){1'b0}}, margin_q, 1'b0};

	// per-request state update and result selection
	always_comb begin
		phase_d  = phase_q;
		moving_d = moving_q;
		start_d  = start_q;
		prev_d   = prev_q;
		still_d  = still_q;
		poll_d   = poll_q;
		max_d    = max_q;
		found    = 1'b0;
		emit     = 1'b0;
		status_d = ST_MAX_FOUND;
		found_d  = '0;
		low_d    = '0;
		high_d   = '0;
		center_d = '0;
		span_d   = '0;
		lim_d    = '0;
		case (cmd_s1)
			CMD_START_MAX, CMD_START_MIN: begin
				phase_d  = (cmd_s1 == CMD_START_MAX) ? PH_MAX : PH_MIN;
				moving_d = 1'b0;
				start_d  = pos_s1;
				prev_d   = pos_s1;
				still_d  = '0;
				poll_d   = '0;
				if (cmd_s1 == CMD_START_MAX) begin
					max_d = POS_MAX;
				end
			end
			default: begin
				if (phase_q != PH_IDLE) begin
					poll_d = poll_q + 1'b1;
					// movement then stillness tracking on good samples
					if (cmd_s1 == CMD_GOOD) begin
						if (!moving_q) begin
							if (abs_diff(pos_s1, start_q) >= travel_q) begin
								moving_d = 1'b1;
								prev_d   = pos_s1;
								still_d  = '0;
							end
						end else if (abs_diff(pos_s1, prev_q) <= tol_q) begin
							if (still_q != STILL_MAX) begin
								still_d = still_q + 1'b1;
							end
							found = (still_d >= needed_q);
						end else begin
							still_d = '0;
							prev_d  = pos_s1;
						end
					end
					emit = found || (poll_d >= poll_limit_q);
					if (emit) begin
						if (!found) begin
							status_d = (phase_q == PH_MAX) ? ST_MAX_TIMEOUT : ST_MIN_TIMEOUT;
						end else if (phase_q == PH_MAX) begin
							max_d    = pos_s1;
							status_d = ST_MAX_FOUND;
							found_d  = pos_s1;
							high_d   = pos_s1;
						end else if (max_q <= pos_s1) begin
							status_d = ST_BAD_ORDER;
							found_d  = pos_s1;
							high_d   = max_q;
						end else begin
							status_d = ST_DONE;
							found_d  = pos_s1;
							low_d    = pos_s1;
							high_d   = max_q;
							center_d = pair_sum[POS_W:1];
							span_d   = span_w;
							lim_d    = signed'(lim_wide[LIM_W-1:0]);
						end
						// back to idle
						phase_d  = PH_IDLE;
						moving_d = 1'b0;
						start_d  = '0;
						prev_d   = '0;
						still_d  = '0;
						poll_d   = '0;
					end
				end
			end
		endcase
	end

	// phase state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			moving_q <= 1'b0;
			start_q  <= '0;
			prev_q   <= '0;
			still_q  <= '0;
			poll_q   <= '0;
			max_q    <= POS_MAX;
		end else if (fire_s1) begin
			phase_q  <= phase_d;
			moving_q <= moving_d;
			start_q  <= start_d;
			prev_q   <= prev_d;
			still_q  <= still_d;
			poll_q   <= poll_d;
			max_q    <= max_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			status_q <= status_d;
			found_q  <= found_d;
			low_q    <= low_d;
			high_q   <= high_d;
			center_q <= center_d;
			span_q   <= span_d;
			lim_q    <= lim_d;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.status          = status_q;
	assign result.found_step      = found_q;
	assign result.low_stop        = low_q;
	assign result.high_stop       = high_q;
	assign result.mid_step        = center_q;
	assign result.span_steps      = span_q;
	assign result.limit_halfsteps = lim_q;

`ifndef NO_ASSERTIONS
	// a phase that reports always returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && emit |=> phase_q == PH_IDLE)
		else $error("phase not idle after result");

	// still counting only happens after movement was seen
	assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> still_q == '0)
		else $error("still count without movement");

	// idle keeps the poll counter and movement flag cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> poll_q == '0 && !moving_q)
		else $error("idle phase with live counters");

	// a finished calibration has ordered stops and a matching span
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && status_q == ST_DONE |->
			low_q < high_q && span_q == high_q - low_q)
		else $error("inconsistent done result");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the end-stop calibrator with sweep requests and register writes. A
// built-in sweep tracker predicts every result, and each result taken from
// the block is checked field by field. A short directed pass covers reset
// values, stop extremes, timeouts and bad order. Random sweeps with random
// settings follow, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import sesc_pkg::*;

	localparam int          ITEM_GOAL  = 1550;
	localparam int          CALM_FROM  = 500;
	localparam int          CALM_TO    = 800;
	localparam int          IDLE_PCT   = 38;
	localparam int          SETTLE_CYC = 4;
	localparam int          TAIL_CYC   = 8;
	localparam int          SHOWN_MAX  = 10;
	localparam int          PLAN_ROWS  = 35;
	localparam longint      LIMIT_NS   = 64'd10_000_000;

	typedef struct packed {
		status_t                 status;
		logic [POS_W-1:0]        found;
		logic [POS_W-1:0]        low;
		logic [POS_W-1:0]        high;
		logic [POS_W-1:0]        center;
		logic [POS_W-1:0]        span;
		logic signed [LIM_W-1:0] limit;
	} sweep_result_t;

	typedef enum logic {
		ROW_REQ   = 1'b0,
		ROW_WRITE = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_reg_t         idx;
		logic [15:0]      data;
		cmd_t             cmd;
		logic [POS_W-1:0] pos;
		logic             lit;
		sweep_result_t    want;
	} plan_row_t;

	localparam sweep_result_t NO_RESULT = '0;

	// directed pass: reset settings first, then extremes and corner cases
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_FAILED, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd4095, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MIN, 12'd100, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd200, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd200, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd202, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd198, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd201, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd199, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd200, 1'b1,
			'{ST_DONE, 12'd200, 12'd200, 12'd4095, 12'd2147, 12'd3895, 13'sd3895}},
		'{ROW_WRITE, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_TOL, 16'd0, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_NEEDED, 16'd1, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_MARGIN, 16'd2047, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_POLL, 16'd65535, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MAX, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd4095, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd4095, 1'b1,
			'{ST_MAX_FOUND, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 13'sd0}},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MIN, 12'd4095, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd0, 1'b1,
			'{ST_DONE, 12'd0, 12'd0, 12'd4095, 12'd2047, 12'd4095, 13'sd1}},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MIN, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd4095, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd4095, 1'b1,
			'{ST_BAD_ORDER, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 13'sd0}},
		'{ROW_WRITE, REG_POLL, 16'd0, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MAX, 12'd10, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_FAILED, 12'd10, 1'b1,
			'{ST_MAX_TIMEOUT, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 13'sd0}},
		'{ROW_WRITE, REG_POLL, 16'd2, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_NEEDED, 16'd0, CMD_GOOD, 12'd0, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MAX, 12'd7, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd7, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_GOOD, 12'd7, 1'b1,
			'{ST_MAX_FOUND, 12'd7, 12'd0, 12'd7, 12'd0, 12'd0, 13'sd0}},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_START_MIN, 12'd10, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_FAILED, 12'd10, 1'b0, NO_RESULT},
		'{ROW_REQ, REG_TRAVEL, 16'd0, CMD_FAILED, 12'd10, 1'b1,
			'{ST_MIN_TIMEOUT, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 13'sd0}}
	};

	logic clk           = 1'b0;
	logic arst_n        = 1'b0;
	logic accept_result = 1'b0;

	sesc_in_if  sample ();
	sesc_out_if result ();
	sesc_cfg_if cfg ();

	assign result.ready = accept_result;

	servo_end_stop_calibrator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	// tracker settings, mirrored from every register write
	logic [THR_W-1:0]    cfg_travel = TRAVEL_RST;
	logic [TOL_W-1:0]    cfg_tol    = TOL_RST;
	logic [STILL_W-1:0]  cfg_needed = NEEDED_RST;
	logic [POLL_W-1:0]   cfg_poll   = POLL_RST;
	logic [MARGIN_W-1:0] cfg_margin = MARGIN_RST;

	// tracker sweep state
	phase_t              sw_phase  = PH_IDLE;
	logic                sw_moving = 1'b0;
	logic [POS_W-1:0]    sw_start  = '0;
	logic [POS_W-1:0]    sw_prev   = '0;
	logic [STILL_W-1:0]  sw_still  = '0;
	logic [POLL_W-1:0]   sw_polls  = '0;
	logic [POS_W-1:0]    sw_max    = POS_MAX;

	sweep_result_t pending_results [$];
	int            error_count = 0;
	int            busy_items  = 0;
	bit            calm        = 1'b0;

	always #10 clk = ~clk;

	function automatic logic [POS_W-1:0] step_gap(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic void arm_sweep(phase_t ph, logic [POS_W-1:0] pos);
		sw_phase  = ph;
		sw_moving = 1'b0;
		sw_start  = pos;
		sw_prev   = pos;
		sw_still  = '0;
		sw_polls  = '0;
	endfunction

	// one request through the sweep tracker; returns 1 when a result is due
	function automatic bit predict_sweep(cmd_t c, logic [POS_W-1:0] p,
		output sweep_result_t r);
		bit               hit;
		logic [POS_W-1:0] span;
		logic [POS_W:0]   sum;
		int               lim;
		r   = '0;
		hit = 1'b0;
		if (c == CMD_START_MAX) begin
			arm_sweep(PH_MAX, p);
			sw_max = POS_MAX;
			return 1'b0;
		end
		if (c == CMD_START_MIN) begin
			arm_sweep(PH_MIN, p);
			return 1'b0;
		end
		if (sw_phase == PH_IDLE)
			return 1'b0;

		// failed reads still count as polls
		sw_polls = sw_polls + 1'b1;
		if (c == CMD_GOOD) begin
			if (!sw_moving) begin
				if (step_gap(p, sw_start) >= cfg_travel) begin
					sw_moving = 1'b1;
					sw_prev   = p;
					sw_still  = '0;
				end
			end else if (step_gap(p, sw_prev) <= cfg_tol) begin
				if (sw_still != STILL_MAX)
					sw_still = sw_still + 1'b1;
				hit = (sw_still >= cfg_needed);
			end else begin
				sw_still = '0;
				sw_prev  = p;
			end
		end
		if (!hit && sw_polls < cfg_poll)
			return 1'b0;

		// phase over: a found stop beats the poll limit
		if (!hit) begin
			r.status = (sw_phase == PH_MAX) ? ST_MAX_TIMEOUT : ST_MIN_TIMEOUT;
		end else if (sw_phase == PH_MAX) begin
			sw_max   = p;
			r.status = ST_MAX_FOUND;
			r.found  = p;
			r.high   = p;
		end else if (sw_max <= p) begin
			r.status = ST_BAD_ORDER;
			r.found  = p;
			r.high   = sw_max;
		end else begin
			span     = sw_max - p;
			sum      = {1'b0, p} + {1'b0, sw_max};
			lim      = int'(span) - 2 * int'(cfg_margin);
			r.status = ST_DONE;
			r.found  = p;
			r.low    = p;
			r.high   = sw_max;
			r.center = sum[POS_W:1];
			r.span   = span;
			r.limit  = lim[LIM_W-1:0];
		end
		arm_sweep(PH_IDLE, '0);
		return 1'b1;
	endfunction

	function automatic void report_error(string what, sweep_result_t want, sweep_result_t got);
		error_count++;
		if (error_count <= SHOWN_MAX) begin
			$write("%0t %s: expected st=%0d f=%0d lo=%0d hi=%0d c=%0d sp=%0d lim=%0d,",
				$time, what, want.status, want.found, want.low, want.high, want.center,
				want.span, want.limit);
			$display(" got st=%0d f=%0d lo=%0d hi=%0d c=%0d sp=%0d lim=%0d",
				got.status, got.found, got.low, got.high, got.center, got.span,
				got.limit);
		end
	endfunction

	function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
		int unsigned usual);
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return lo;
		if (roll == 1)
			return hi;
		return $urandom_range(usual, lo);
	endfunction

	// send one sweep request and book its expected result
	task automatic send_request(cmd_t c, logic [POS_W-1:0] p, logic lit, sweep_result_t want);
		sweep_result_t r;
		bit            due;
		bit            ignored;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid    <= 1'b1;
		sample.cmd      <= c;
		sample.position <= p;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		ignored = (c == CMD_GOOD || c == CMD_FAILED) && sw_phase == PH_IDLE;
		due = predict_sweep(c, p, r);
		if (lit)
			pending_results.push_back(want);
		else if (due)
			pending_results.push_back(r);
		if (!ignored)
			busy_items++;
		calm = (busy_items >= CALM_FROM && busy_items < CALM_TO);
	endtask

	// register write, only once the block has gone quiet
	task automatic write_register(cfg_reg_t idx, logic [15:0] val);
		sample.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_TRAVEL: cfg_travel = val[THR_W-1:0];
			REG_TOL:    cfg_tol    = val[TOL_W-1:0];
			REG_NEEDED: cfg_needed = val[STILL_W-1:0];
			REG_POLL:   cfg_poll   = val[POLL_W-1:0];
			REG_MARGIN: cfg_margin = val[MARGIN_W-1:0];
			default: ;
		endcase
	endtask

	// one phase: start, travel toward a goal, then settle near it
	task automatic run_phase(cmd_t start);
		int origin;
		int goal;
		int jit;
		int spot;
		int budget;
		origin = $urandom_range(4095);
		if ($urandom_range(5) == 0)
			goal = $urandom_range(4095);
		else if (start == CMD_START_MAX)
			goal = $urandom_range(4095, 2048);
		else
			goal = $urandom_range(2047, 0);
		send_request(start, POS_W'(origin), 1'b0, NO_RESULT);
		budget = int'(cfg_needed) + 30;
		while (sw_phase != PH_IDLE && budget > 0) begin
			budget--;
			case ($urandom_range(19))
				0: send_request(CMD_FAILED, POS_W'($urandom_range(4095)), 1'b0, NO_RESULT);
				1: send_request(CMD_GOOD, POS_W'($urandom_range(4095)), 1'b0, NO_RESULT);
				default: begin
					if (!sw_moving) begin
						spot = $urandom_range(1) ? goal : (origin + goal) / 2;
					end else begin
						jit  = $urandom_range(((cfg_tol > 40) ? 40 : int'(cfg_tol)) / 2);
						spot = $urandom_range(1) ? goal + jit : goal - jit;
						if (spot < 0)
							spot = 0;
						if (spot > 4095)
							spot = 4095;
					end
					send_request(CMD_GOOD, POS_W'(spot), 1'b0, NO_RESULT);
				end
			endcase
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		sweep_result_t seen;
		sweep_result_t due;
		if (result.valid && result.ready) begin
			seen = {result.status, result.found_step, result.low_stop, result.high_stop,
				result.mid_step, result.span_steps, result.limit_halfsteps};
			if (pending_results.size() == 0) begin
				report_error("result with none expected", NO_RESULT, seen);
			end else begin
				due = pending_results.pop_front();
				if (due.status != seen.status || due.found != seen.found ||
					due.low != seen.low || due.high != seen.high ||
					due.center != seen.center || due.span != seen.span ||
					due.limit != seen.limit)
					report_error("result mismatch", due, seen);
			end
		end
		accept_result <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// main sequence
	initial begin
		sample.valid    <= 1'b0;
		sample.cmd      <= CMD_START_MAX;
		sample.position <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= REG_TRAVEL;
		cfg.data        <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_WRITE)
				write_register(PLAN[i].idx, PLAN[i].data);
			else
				send_request(PLAN[i].cmd, PLAN[i].pos, PLAN[i].lit, PLAN[i].want);
		end

		// random settings, each set followed by two to six rounds of sweeps or stray requests
		while (busy_items < ITEM_GOAL) begin
			write_register(REG_TRAVEL,
				16'(pick_setting(0, 4095, 150)) | (16'($urandom) & 16'hF000));
			write_register(REG_TOL,
				16'(pick_setting(0, 4095, 20)) | (16'($urandom) & 16'hF000));
			write_register(REG_NEEDED,
				16'(pick_setting(0, 255, 12)) | (16'($urandom) & 16'hFF00));
			write_register(REG_POLL, 16'(pick_setting(0, 65535, 400)));
			write_register(REG_MARGIN,
				16'(pick_setting(0, 2047, 1000)) | (16'($urandom) & 16'hF800));
			repeat ($urandom_range(6, 2)) begin
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(8, 1))
						send_request(cmd_t'($urandom_range(3)), POS_W'($urandom_range(4095)),
							1'b0, NO_RESULT);
				end else begin
					if ($urandom_range(7) != 0)
						run_phase(CMD_START_MAX);
					run_phase(CMD_START_MIN);
				end
			end
		end

		// drain and report
		sample.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		error_count += pending_results.size();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: servo_end_stop_calibrator_unit.f
src/sesc_pkg.sv
src/sesc_if.sv
src/servo_end_stop_calibrator_unit.sv
tb/sv/testbench.sv
